/* design/kebd_pkg.sv */
// Package for the keyed event burst detector.
// Holds the result status codes, register indexes and the configuration struct.
// No dependencies; every other design file refers to it by scoped names.
package kebd_pkg;

   // Result status codes.
   localparam logic [2:0] STATUS_IGNORED  = 3'd0;
   localparam logic [2:0] STATUS_RECORDED = 3'd1;
   localparam logic [2:0] STATUS_BURST    = 3'd2;
   localparam logic [2:0] STATUS_DROPPED  = 3'd3;
   localparam logic [2:0] STATUS_FULL     = 3'd4;

   // Register indexes on the configuration port.
   localparam logic REG_REPORT_ENABLE = 1'b0;
   localparam logic REG_WINDOW_LIMIT  = 1'b1;

   localparam logic [5:0] WINDOW_LIMIT_RESET = 6'd60;

   // Highest queue number that is processed.
   localparam logic [2:0] QUEUE_MAX = 3'd3;

   // A burst is a span of at least one and fewer than this many seconds.
   localparam logic [23:0] BURST_SPAN_LIMIT = 24'd61;

   localparam int STAMP_W = 23;
   localparam int CHAN_W  = 32;
   localparam int COUNT_W = 32;
   localparam int KEY_W   = 34;

   typedef struct packed {
      logic       report_enable;
      logic [5:0] window_limit;
   } cfg_type;

endpackage

/* design/keyed_event_burst_detector.sv */
// Keyed event burst detector. Each request (queue number, channel index, count,
// timestamp) is looked up in a table of up to MAX_KEYS keys and its timestamp is
// pushed into that key's ring; when the ring is full and its newest and oldest
// stamps lie 1 to 60 seconds apart, the count is reported and the ring emptied.
// One request is handled at a time. The sequential search looks at one key-table
// entry per cycle, up to the entry that holds the key, or past every key in use for
// a new key. When window_limit was lowered, a stored ring position is reduced by
// repeated subtraction in the single shared subtractor. A request whose key does
// not fit in a full table gets STATUS_FULL once the search has passed every entry.
// A finished result waits in an output register, so the next request is taken while
// it is pending; the block stalls only when a second result is ready before the
// first is taken. Ignored requests skip the search and the window test. The
// timestamp memory needs no clearing pass.
// Depends on kebd_pkg and kebd_csr.
module keyed_event_burst_detector #(
   parameter int MAX_KEYS   = 16,
   parameter int RING_DEPTH = 60
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [2:0]  req_queue_num,
   input  logic [31:0] req_chan_index,
   input  logic [31:0] req_event_count,
   input  logic [22:0] req_time_sec,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [2:0]  rsp_status,
   output logic [31:0] rsp_report_count,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   localparam int KW       = (MAX_KEYS > 1) ? $clog2(MAX_KEYS) : 1;
   localparam int UW       = $clog2(MAX_KEYS + 1);
   localparam int PW       = $clog2(RING_DEPTH);
   localparam int FW       = $clog2(RING_DEPTH + 1);
   localparam int MemDepth = MAX_KEYS * RING_DEPTH;
   localparam int AW       = $clog2(MemDepth);
   localparam int ResetLim = (RING_DEPTH < int'(kebd_pkg::WINDOW_LIMIT_RESET)) ?
                             RING_DEPTH : int'(kebd_pkg::WINDOW_LIMIT_RESET);
   localparam int SW       = kebd_pkg::STAMP_W;

   localparam logic [3:0] S_IDLE   = 4'd0;
   localparam logic [3:0] S_SEARCH = 4'd1;
   localparam logic [3:0] S_LOAD   = 4'd2;
   localparam logic [3:0] S_MODH   = 4'd3;
   localparam logic [3:0] S_MODT   = 4'd4;
   localparam logic [3:0] S_STORE  = 4'd5;
   localparam logic [3:0] S_RDNEW  = 4'd6;
   localparam logic [3:0] S_RDOLD  = 4'd7;
   localparam logic [3:0] S_CMP    = 4'd8;
   localparam logic [3:0] S_FINISH = 4'd9;

   kebd_pkg::cfg_type cfg;

   kebd_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (csr_psel),
      .penable (csr_penable),
      .pwrite  (csr_pwrite),
      .paddr   (csr_paddr),
      .pwdata  (csr_pwdata),
      .prdata  (csr_prdata),
      .pready  (csr_pready),
      .cfg     (cfg)
   );

   // Sequencer and working registers.
   logic [3:0]              state_ff, state_in;
   logic [2:0]              queue_ff, queue_in;
   logic [31:0]             chan_ff, chan_in;
   logic [31:0]             count_ff, count_in;
   logic [SW-1:0]           stamp_ff, stamp_in;
   logic [FW-1:0]           lim_ff, lim_in;
   logic [UW-1:0]           idx_ff, idx_in;
   logic [KW-1:0]           k_ff, k_in;
   logic [AW-1:0]           base_ff, base_in;
   logic [PW-1:0]           mod_ff, mod_in;
   logic [PW-1:0]           head_pos_ff, head_pos_in;
   logic [PW-1:0]           tail_pos_ff, tail_pos_in;
   logic [FW-1:0]           fill_ff, fill_in;
   logic [SW-1:0]           newest_ff, newest_in;
   logic [2:0]              status_ff, status_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [2:0]              rsp_status_ff, rsp_status_in;
   logic [31:0]             rsp_count_ff, rsp_count_in;

   // Key table and per-key ring pointers.
   logic [kebd_pkg::KEY_W-1:0] key_store_ff [MAX_KEYS];
   logic [UW-1:0]           key_used_ff, key_used_in;
   logic [PW-1:0]           ring_head_ff [MAX_KEYS];
   logic [PW-1:0]           ring_tail_ff [MAX_KEYS];
   logic [FW-1:0]           ring_fill_ff [MAX_KEYS];

   // Timestamp memory.
   logic [SW-1:0]           stamp_mem [MemDepth];
   logic [SW-1:0]           mem_rdata_ff;

   // Write controls for the table, pointers and memory.
   logic                    key_we;
   logic                    head_we, tail_we, fill_we;
   logic [KW-1:0]           ring_wr_idx;
   logic [PW-1:0]           head_wr, tail_wr;
   logic [FW-1:0]           fill_wr;
   logic                    mem_we;
   logic [AW-1:0]           mem_waddr, mem_raddr;

   logic [kebd_pkg::KEY_W-1:0] req_key;
   logic [FW-1:0]           lim_calc;
   logic                    mod_ge;
   logic [PW-1:0]           slot;
   logic [FW-1:0]           fill_after;
   logic [SW:0]             stamp_diff;
   logic                    is_burst;
   logic                    out_free;

   assign req_ready = (state_ff == S_IDLE);
   assign req_key   = {queue_ff[1:0], chan_ff};
   assign out_free  = ~rsp_valid_ff | rsp_ready;

   always_comb begin
      if (cfg.window_limit == 6'd0) begin
         lim_calc = FW'(1);
      end else if (32'(cfg.window_limit) > RING_DEPTH) begin
         lim_calc = FW'(RING_DEPTH);
      end else begin
         lim_calc = FW'(cfg.window_limit);
      end
   end

   // The shared subtractor reduces a stored ring position modulo the limit.
   assign mod_ge = (FW'(mod_ff) >= lim_ff);

   always_comb begin
      if (fill_ff == '0) begin
         slot = head_pos_ff;
      end else if (FW'(tail_pos_ff) + FW'(1) == lim_ff) begin
         slot = '0;
      end else begin
         slot = tail_pos_ff + PW'(1);
      end
      fill_after = (fill_ff < lim_ff) ? fill_ff + FW'(1) : fill_ff;
   end

   assign stamp_diff = {1'b0, newest_ff} - {1'b0, mem_rdata_ff};
   assign is_burst   = ~stamp_diff[SW] && (stamp_diff != '0) &&
                       (stamp_diff < kebd_pkg::BURST_SPAN_LIMIT);

   assign mem_waddr = base_ff + AW'(slot);
   assign mem_raddr = base_ff + AW'((state_ff == S_RDNEW) ? tail_pos_ff : head_pos_ff);

   always_comb begin
      state_in     = state_ff;
      queue_in     = queue_ff;
      chan_in      = chan_ff;
      count_in     = count_ff;
      stamp_in     = stamp_ff;
      lim_in       = lim_ff;
      idx_in       = idx_ff;
      k_in         = k_ff;
      base_in      = base_ff;
      mod_in       = mod_ff;
      head_pos_in  = head_pos_ff;
      tail_pos_in  = tail_pos_ff;
      fill_in      = fill_ff;
      newest_in    = newest_ff;
      status_in    = status_ff;
      key_used_in  = key_used_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_ready;
      rsp_status_in = rsp_status_ff;
      rsp_count_in = rsp_count_ff;
      key_we       = 1'b0;
      head_we      = 1'b0;
      tail_we      = 1'b0;
      fill_we      = 1'b0;
      ring_wr_idx  = k_ff;
      head_wr      = '0;
      tail_wr      = PW'(lim_ff - FW'(1));
      fill_wr      = '0;
      mem_we       = 1'b0;

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               queue_in = req_queue_num;
               chan_in  = req_chan_index;
               count_in = req_event_count;
               stamp_in = req_time_sec;
               lim_in   = lim_calc;
               idx_in   = '0;
               if (!cfg.report_enable || req_queue_num > kebd_pkg::QUEUE_MAX) begin
                  status_in = kebd_pkg::STATUS_IGNORED;
                  state_in  = S_FINISH;
               end else begin
                  state_in = S_SEARCH;
               end
            end
         end
         S_SEARCH: begin
            if (idx_ff == key_used_ff) begin
               if (32'(key_used_ff) >= MAX_KEYS) begin
                  status_in = kebd_pkg::STATUS_FULL;
                  state_in  = S_FINISH;
               end else begin
                  // New key: take the next free entry and start an empty ring.
                  key_we      = 1'b1;
                  ring_wr_idx = key_used_ff[KW-1:0];
                  head_we     = 1'b1;
                  tail_we     = 1'b1;
                  fill_we     = 1'b1;
                  k_in        = key_used_ff[KW-1:0];
                  key_used_in = key_used_ff + UW'(1);
                  state_in    = S_LOAD;
               end
            end else if (key_store_ff[idx_ff[KW-1:0]] == req_key) begin
               k_in     = idx_ff[KW-1:0];
               state_in = S_LOAD;
            end else begin
               idx_in = idx_ff + UW'(1);
            end
         end
         S_LOAD: begin
            base_in  = AW'(32'(k_ff) * RING_DEPTH);
            mod_in   = ring_head_ff[k_ff];
            fill_in  = ring_fill_ff[k_ff];
            state_in = S_MODH;
         end
         S_MODH: begin
            if (mod_ge) begin
               mod_in = mod_ff - PW'(lim_ff);
            end else begin
               head_pos_in = mod_ff;
               mod_in      = ring_tail_ff[k_ff];
               state_in    = S_MODT;
            end
         end
         S_MODT: begin
            if (mod_ge) begin
               mod_in = mod_ff - PW'(lim_ff);
            end else begin
               tail_pos_in = mod_ff;
               state_in    = S_STORE;
            end
         end
         S_STORE: begin
            if (fill_ff < lim_ff) begin
               mem_we      = 1'b1;
               tail_we     = 1'b1;
               tail_wr     = slot;
               fill_we     = 1'b1;
               fill_wr     = fill_after;
               tail_pos_in = slot;
            end
            fill_in = fill_after;
            if (fill_after == lim_ff) begin
               state_in = S_RDNEW;
            end else begin
               status_in = kebd_pkg::STATUS_RECORDED;
               state_in  = S_FINISH;
            end
         end
         S_RDNEW: begin
            state_in = S_RDOLD;
         end
         S_RDOLD: begin
            newest_in = mem_rdata_ff;
            state_in  = S_CMP;
         end
         S_CMP: begin
            head_we = 1'b1;
            fill_we = 1'b1;
            if (is_burst) begin
               tail_we   = 1'b1;
               status_in = kebd_pkg::STATUS_BURST;
            end else begin
               head_wr   = (FW'(head_pos_ff) + FW'(1) == lim_ff) ? '0 :
                           head_pos_ff + PW'(1);
               fill_wr   = fill_ff - FW'(1);
               status_in = kebd_pkg::STATUS_DROPPED;
            end
            state_in = S_FINISH;
         end
         S_FINISH: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = status_ff;
               rsp_count_in  = (status_ff == kebd_pkg::STATUS_BURST) ? count_ff : 32'd0;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         key_used_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         key_used_ff  <= key_used_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      queue_ff      <= queue_in;
      chan_ff       <= chan_in;
      count_ff      <= count_in;
      stamp_ff      <= stamp_in;
      lim_ff        <= lim_in;
      idx_ff        <= idx_in;
      k_ff          <= k_in;
      base_ff       <= base_in;
      mod_ff        <= mod_in;
      head_pos_ff   <= head_pos_in;
      tail_pos_ff   <= tail_pos_in;
      fill_ff       <= fill_in;
      newest_ff     <= newest_in;
      status_ff     <= status_in;
      rsp_status_ff <= rsp_status_in;
      rsp_count_ff  <= rsp_count_in;
   end

   always_ff @(posedge clock) begin
      if (key_we) begin
         key_store_ff[ring_wr_idx] <= req_key;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < MAX_KEYS; i++) begin
            ring_head_ff[i] <= '0;
            ring_tail_ff[i] <= PW'(ResetLim - 1);
            ring_fill_ff[i] <= '0;
         end
      end else begin
         if (head_we) begin
            ring_head_ff[ring_wr_idx] <= head_wr;
         end
         if (tail_we) begin
            ring_tail_ff[ring_wr_idx] <= tail_wr;
         end
         if (fill_we) begin
            ring_fill_ff[ring_wr_idx] <= fill_wr;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         stamp_mem[mem_waddr] <= stamp_ff;
      end
      mem_rdata_ff <= stamp_mem[mem_raddr];
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_report_count = rsp_count_ff;

endmodule

/* design/kebd_csr.sv */
// Configuration registers of the keyed event burst detector.
// APB-style slave with two registers; uses kebd_pkg for the indexes and the
// configuration struct.
module kebd_csr (
   input  logic             clock,
   input  logic             reset,
   input  logic             psel,
   input  logic             penable,
   input  logic             pwrite,
   input  logic [2:0]       paddr,
   input  logic [31:0]      pwdata,
   output logic [31:0]      prdata,
   output logic             pready,
   output kebd_pkg::cfg_type cfg
);

   logic       report_enable_ff, report_enable_in;
   logic [5:0] window_limit_ff, window_limit_in;
   logic       reg_index;
   logic       wr_fire;

   assign pready    = 1'b1;
   assign reg_index = paddr[2];
   assign wr_fire   = psel & penable & pwrite;

   always_comb begin
      report_enable_in = report_enable_ff;
      window_limit_in  = window_limit_ff;
      if (wr_fire) begin
         case (reg_index)
            kebd_pkg::REG_REPORT_ENABLE: report_enable_in = pwdata[0];
            kebd_pkg::REG_WINDOW_LIMIT:  window_limit_in  = pwdata[5:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         report_enable_ff <= 1'b0;
         window_limit_ff  <= kebd_pkg::WINDOW_LIMIT_RESET;
      end else begin
         report_enable_ff <= report_enable_in;
         window_limit_ff  <= window_limit_in;
      end
   end

   always_comb begin
      case (reg_index)
         kebd_pkg::REG_REPORT_ENABLE: prdata = {31'd0, report_enable_ff};
         kebd_pkg::REG_WINDOW_LIMIT:  prdata = {26'd0, window_limit_ff};
         default:                     prdata = 32'd0;
      endcase
   end

   assign cfg.report_enable = report_enable_ff;
   assign cfg.window_limit  = window_limit_ff;

endmodule

/* design/kebd_checker.sv */
// Port-level checker for the keyed event burst detector, with its bind.
// Depends on kebd_pkg for the status codes.
module kebd_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic [2:0]  req_queue_num,
   input logic [31:0] req_chan_index,
   input logic [31:0] req_event_count,
   input logic [22:0] req_time_sec,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [2:0]  rsp_status,
   input logic [31:0] rsp_report_count
);

   // A pending result holds until it is taken.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status) &&
                                  $stable(rsp_report_count))
      else $error("pending result changed before it was taken");

   // Only a burst carries a count.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != kebd_pkg::STATUS_BURST |-> rsp_report_count == 32'd0)
      else $error("count reported without a burst");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_status <= kebd_pkg::STATUS_FULL)
      else $error("undefined status code");

   // The block works on one request at a time.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while the previous one is in progress");

   // A waiting request keeps its payload.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_ready |=> req_valid && $stable(req_queue_num) &&
                                  $stable(req_chan_index) && $stable(req_event_count) &&
                                  $stable(req_time_sec))
      else $error("waiting request changed before it was taken");

endmodule

bind keyed_event_burst_detector kebd_checker u_kebd_checker (.*);
